// ===== rtl/gep_pkg.sv =====
// Shared types, constants and arithmetic helpers of the gradient edge-point detector.
package gep_pkg;

    localparam int PIX_W   = 24;
    localparam int COORD_W = 12;
    localparam int GRAY_W  = 8;
    localparam int DIFF_W  = 9;
    localparam int ROWS    = 5;
    localparam int HIST_D  = 3;

    typedef logic [GRAY_W-1:0] t_gray;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef t_gray t_gray_col [ROWS];
    typedef t_diff t_hist [HIST_D];

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [GRAY_W-1:0]  horiz_strength;
        logic [DIFF_W-1:0]  diag_left;
        logic [GRAY_W-1:0]  vert_strength;
        logic [DIFF_W-1:0]  diag_right;
    } t_point;

    function automatic t_gray to_gray(input logic [PIX_W-1:0] rgb);
        logic [12:0] sum;
        sum = 13'(rgb[23:16]) * 13'd11 + {1'b0, rgb[15:8], 4'b0000} + 13'(rgb[7:0]) * 13'd5;
        return sum[12:5];
    endfunction

    function automatic t_diff gray_diff(input t_gray a, input t_gray b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic t_gray extremum(input t_diff far_d, input t_diff near_d,
                                       input t_diff mid_d, input t_diff next_d);
        logic  cand;
        logic  keep;
        t_diff mag;
        cand = (mid_d >= near_d && mid_d > next_d) || (mid_d <= near_d && mid_d < next_d);
        keep = (mid_d > next_d && near_d > far_d) || (mid_d < next_d && near_d < far_d);
        mag  = (mid_d < 0) ? -mid_d : mid_d;
        if (!cand) begin
            return '0;
        end else if (mid_d == near_d && !keep) begin
            return '0;
        end
        return mag[GRAY_W-1:0];
    endfunction

endpackage

// ===== rtl/gep_eval.sv =====
// Evaluation of one registered column: extremum tests, point fields and next history.
module gep_eval (
    input  gep_pkg::t_gray_col                 i_cur,
    input  gep_pkg::t_gray_col                 i_prev,
    input  gep_pkg::t_gray                     i_older_top,
    input  gep_pkg::t_hist                     i_hist,
    input  logic [gep_pkg::COORD_W-1:0]        i_col,
    input  logic [gep_pkg::COORD_W-1:0]        i_line,
    output gep_pkg::t_point                    o_point,
    output logic                               o_hit,
    output gep_pkg::t_hist                     o_next_hist,
    output gep_pkg::t_gray                     o_next_older
);

    gep_pkg::t_gray_col eff_prev;
    gep_pkg::t_hist     eff_hist;
    gep_pkg::t_gray     eff_older;
    gep_pkg::t_gray     center;
    gep_pkg::t_diff     next_dx;
    gep_pkg::t_diff     v_up;
    gep_pkg::t_diff     v_mid;
    gep_pkg::t_diff     v_down;
    gep_pkg::t_diff     v_far;
    gep_pkg::t_gray     hs;
    gep_pkg::t_gray     vs;
    logic               clear;

    always_comb begin
        clear = (i_col == '0);
        for (int i = 0; i < gep_pkg::ROWS; i++) begin
            eff_prev[i] = clear ? '0 : i_prev[i];
        end
        for (int i = 0; i < gep_pkg::HIST_D; i++) begin
            eff_hist[i] = clear ? '0 : i_hist[i];
        end
        eff_older = clear ? '0 : i_older_top;

        center  = eff_prev[2];
        next_dx = gep_pkg::gray_diff(center, i_cur[2]);
        hs = gep_pkg::extremum(eff_hist[2], eff_hist[1], eff_hist[0], next_dx);

        v_up   = gep_pkg::gray_diff(eff_prev[0], eff_prev[1]);
        v_mid  = gep_pkg::gray_diff(eff_prev[1], eff_prev[2]);
        v_down = gep_pkg::gray_diff(eff_prev[2], eff_prev[3]);
        v_far  = gep_pkg::gray_diff(eff_prev[3], eff_prev[4]);
        vs = gep_pkg::extremum(v_far, v_down, v_mid, v_up);

        o_hit = (hs != '0 || vs != '0) && (i_col > 12'd1) && (i_line > 12'd1);

        o_point.point_x        = i_col - 12'd1;
        o_point.point_y        = i_line - 12'd1;
        o_point.horiz_strength = hs;
        o_point.diag_left      = gep_pkg::gray_diff(center, eff_older);
        o_point.vert_strength  = vs;
        o_point.diag_right     = gep_pkg::gray_diff(center, i_cur[1]);

        o_next_hist[2] = eff_hist[1];
        o_next_hist[1] = eff_hist[0];
        o_next_hist[0] = next_dx;
        o_next_older   = eff_prev[1];
    end

endmodule

// ===== rtl/gradient_extremum_edge_points.sv =====
// Top level of the gradient edge-point detector on a stream of image columns.
// One column transaction is accepted every clock unless a stall stops intake; a column is
// held in the input register and its point in the result register, and all gray conversion
// and extremum tests sit in the single logic stage between them. Columns that give no point
// simply leave the pipeline. A stalled output holds its point and stops intake only when
// both registers are full. Column zero restarts the history.
module gradient_extremum_edge_points #(
    parameter int COORD_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pix_row_m3, pix_row_m2, pix_row_m1, pix_row_0, pix_row_p1, column_index, line_index
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // point_x, point_y, horiz_strength, diag_left, vert_strength, diag_right, zero pad
    output logic [63:0]   m_axis_tdata
);

    localparam int Cw = gep_pkg::COORD_W;
    localparam logic [Cw-1:0] CoordMask = Cw'((1 << COORD_BITS) - 1);

    logic                 r_in_valid;
    logic [143:0]         r_in_data;
    logic                 r_out_valid;
    logic [63:0]          r_out_data;
    gep_pkg::t_gray_col   r_prev;
    gep_pkg::t_gray       r_older;
    gep_pkg::t_hist       r_hist;

    gep_pkg::t_gray_col   cur;
    gep_pkg::t_point      point;
    logic                 hit;
    gep_pkg::t_hist       n_hist;
    gep_pkg::t_gray       n_older;
    logic [63:0]          n_out_data;
    logic                 adv;

    always_comb begin
        for (int i = 0; i < gep_pkg::ROWS; i++) begin
            cur[i] = gep_pkg::to_gray(r_in_data[i*gep_pkg::PIX_W +: gep_pkg::PIX_W]);
        end
    end

    gep_eval u_eval (
        .i_cur        (cur),
        .i_prev       (r_prev),
        .i_older_top  (r_older),
        .i_hist       (r_hist),
        .i_col        (r_in_data[131:120]),
        .i_line       (r_in_data[143:132]),
        .o_point      (point),
        .o_hit        (hit),
        .o_next_hist  (n_hist),
        .o_next_older (n_older)
    );

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign n_out_data = {6'b0, point.diag_right, point.vert_strength, point.diag_left,
                         point.horiz_strength, point.point_y & CoordMask,
                         point.point_x & CoordMask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_older     <= '0;
            for (int i = 0; i < gep_pkg::ROWS; i++) begin
                r_prev[i] <= '0;
            end
            for (int i = 0; i < gep_pkg::HIST_D; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && hit;
                if (r_in_valid) begin
                    r_prev  <= cur;
                    r_older <= n_older;
                    r_hist  <= n_hist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
        if (adv && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== rtl/gep_checker.sv =====
// Port-level checker of the gradient edge-point detector and its bind to the top level.
module gep_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic [143:0]  s_axis_tdata,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [63:0]   m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output transaction changed.");

    a_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] != 8'd0 || m_axis_tdata[48:41] != 8'd0))
        else $error("Point emitted with both strengths zero.");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:58] == 6'd0)
        else $error("Output pad bits are not zero.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

bind gradient_extremum_edge_points gep_checker u_gep_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
